>>> src/sts_pkg.sv
// ----------------------------------------------------------------------------
// sts_pkg
// Types, token codes and character helpers for the script token scanner.
// ----------------------------------------------------------------------------
package sts_pkg;

    localparam int POS_WIDTH_DEFAULT = 16;
    localparam int FIELD_WIDTH       = 16;
    localparam int MAX_RESULTS       = 3;
    localparam int NUM_KEYWORDS      = 7;

    // token kinds
    localparam logic [4:0] KIND_END   = 5'd0;
    localparam logic [4:0] KIND_EOL   = 5'd1;
    localparam logic [4:0] KIND_PLUS  = 5'd2;
    localparam logic [4:0] KIND_MINUS = 5'd3;
    localparam logic [4:0] KIND_SLASH = 5'd4;
    localparam logic [4:0] KIND_STAR  = 5'd5;
    localparam logic [4:0] KIND_LPAR  = 5'd6;
    localparam logic [4:0] KIND_RPAR  = 5'd7;
    localparam logic [4:0] KIND_ARROW = 5'd8;
    localparam logic [4:0] KIND_DOT   = 5'd9;
    localparam logic [4:0] KIND_LE    = 5'd10;
    localparam logic [4:0] KIND_GE    = 5'd11;
    localparam logic [4:0] KIND_EQ    = 5'd12;
    localparam logic [4:0] KIND_ASSIGN = 5'd13;
    localparam logic [4:0] KIND_LT    = 5'd14;
    localparam logic [4:0] KIND_GT    = 5'd15;
    localparam logic [4:0] KIND_LBRACE = 5'd16;
    localparam logic [4:0] KIND_RBRACE = 5'd17;
    localparam logic [4:0] KIND_COMMA = 5'd18;
    localparam logic [4:0] KIND_COLON = 5'd19;
    localparam logic [4:0] KIND_KW0   = 5'd20;
    localparam logic [4:0] KIND_NUM   = 5'd27;
    localparam logic [4:0] KIND_ID    = 5'd28;
    localparam logic [4:0] KIND_STR   = 5'd29;
    localparam logic [4:0] KIND_UNK   = 5'd30;

    // characters
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_UNDER  = 8'h5F;

    // keywords, right-aligned ASCII, in kind order
    localparam logic [63:0] KW_TEXT [NUM_KEYWORDS] = '{
        64'h0000_0077_6869_6C65,   // while
        64'h0000_0000_0066_6F72,   // for
        64'h6675_6E63_7469_6F6E,   // function
        64'h0000_0063_6C61_7373,   // class
        64'h0000_0000_0000_6966,   // if
        64'h0000_0000_656C_7365,   // else
        64'h0000_7265_7475_726E    // return
    };
    localparam logic [3:0] KW_LEN [NUM_KEYWORDS] = '{
        4'd5, 4'd3, 4'd8, 4'd5, 4'd2, 4'd4, 4'd6
    };

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_NUM,
        MODE_IDENT,
        MODE_STR,
        MODE_COMMENT,
        MODE_PEND
    } scan_mode_t;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       text_end;
    } text_item_t;

    typedef struct packed {
        logic [4:0]             token_kind;
        logic [FIELD_WIDTH-1:0] token_offset;
        logic [FIELD_WIDTH-1:0] token_length;
        logic [FIELD_WIDTH-1:0] token_line;
        logic [FIELD_WIDTH-1:0] token_column;
        logic                   run_end;
    } token_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

    function automatic logic is_word(input logic [7:0] c);
        return is_alpha(c) || is_digit(c) || (c == CH_UNDER);
    endfunction

    // single-character operator kind, KIND_END when the byte is not one
    function automatic logic [4:0] single_kind(input logic [7:0] c);
        logic [4:0] k;
        case (c)
            8'h2B:   k = KIND_PLUS;
            8'h2D:   k = KIND_MINUS;
            8'h2F:   k = KIND_SLASH;
            8'h2A:   k = KIND_STAR;
            8'h28:   k = KIND_LPAR;
            8'h29:   k = KIND_RPAR;
            8'h2E:   k = KIND_DOT;
            8'h3D:   k = KIND_ASSIGN;
            8'h3C:   k = KIND_LT;
            8'h3E:   k = KIND_GT;
            8'h7B:   k = KIND_LBRACE;
            8'h7D:   k = KIND_RBRACE;
            8'h2C:   k = KIND_COMMA;
            8'h3A:   k = KIND_COLON;
            default: k = KIND_END;
        endcase
        return k;
    endfunction

endpackage

>>> src/script_token_scanner.sv
// ----------------------------------------------------------------------------
// script_token_scanner
// Streaming lexer: one source byte in, up to three tokens out per byte.
// ----------------------------------------------------------------------------
//  channel  ports                      payload          item
//  input    s_valid s_ready s_data     text_item_t      one source byte
//  output   m_valid m_ready m_data     token_t          one token
//
//  A byte is taken every cycle while the output holds at most one token that
//  leaves in the same cycle. Its tokens are registered into a three-slot
//  result buffer and appear in the cycle after the byte is taken, one per
//  cycle while m_ready is high.
//  Reset clears the scan state and empties the result buffer.
//  A stalled output holds the buffer and, while any token waits, the input.
// ----------------------------------------------------------------------------
module script_token_scanner #(
    parameter int POS_WIDTH = sts_pkg::POS_WIDTH_DEFAULT
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  sts_pkg::text_item_t s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output sts_pkg::token_t     m_data
);

    typedef logic [POS_WIDTH-1:0] pos_t;

    localparam pos_t POS_ONE = POS_WIDTH'(1);
    localparam pos_t POS_TWO = POS_WIDTH'(2);
    localparam pos_t WORD_MAX = POS_WIDTH'(8);

    // scan state
    sts_pkg::scan_mode_t mode_reg, mode_next;
    logic [7:0]  held_reg, held_next;
    pos_t        ts_reg, ts_next;
    pos_t        tl_reg, tl_next;
    pos_t        tln_reg, tln_next;
    pos_t        tc_reg, tc_next;
    pos_t        off_reg, off_next;
    pos_t        line_reg, line_next;
    pos_t        col_reg, col_next;
    logic [63:0] wb_reg, wb_next;
    logic        wf_reg, wf_next;

    // result buffer
    sts_pkg::token_t slot_reg [sts_pkg::MAX_RESULTS];
    logic [1:0]      count_reg;
    sts_pkg::token_t res [sts_pkg::MAX_RESULTS];
    logic [1:0]      res_n;

    logic s_fire, m_fire;

    function automatic pos_t inc_sat(input pos_t x);
        return (x != '1) ? x + POS_ONE : x;
    endfunction

    function automatic sts_pkg::token_t make_tok(input logic [4:0] kind, input pos_t off,
                                                 input pos_t len, input pos_t ln,
                                                 input pos_t col);
        sts_pkg::token_t t;
        t.token_kind   = kind;
        t.token_offset = sts_pkg::FIELD_WIDTH'(off);
        t.token_length = sts_pkg::FIELD_WIDTH'(len);
        t.token_line   = sts_pkg::FIELD_WIDTH'(ln);
        t.token_column = sts_pkg::FIELD_WIDTH'(col);
        t.run_end      = 1'b0;
        return t;
    endfunction

    function automatic logic [4:0] word_kind(input logic fits, input logic [63:0] wb,
                                             input pos_t len);
        logic [4:0] k;
        k = sts_pkg::KIND_ID;
        if (fits) begin
            for (int i = 0; i < sts_pkg::NUM_KEYWORDS; i++) begin
                if ((len == POS_WIDTH'(sts_pkg::KW_LEN[i])) && (wb == sts_pkg::KW_TEXT[i]))
                    k = sts_pkg::KIND_KW0 + 5'(i);
            end
        end
        return k;
    endfunction

    // open token kind; has is low when nothing is pending
    function automatic logic [5:0] open_token(input sts_pkg::scan_mode_t m,
                                              input logic [7:0] held, input logic fits,
                                              input logic [63:0] wb, input pos_t len);
        logic       has;
        logic [4:0] k;
        has = 1'b1;
        k   = sts_pkg::KIND_END;
        unique case (m)
            sts_pkg::MODE_NUM:   k = sts_pkg::KIND_NUM;
            sts_pkg::MODE_IDENT: k = word_kind(fits, wb, len);
            sts_pkg::MODE_STR:   k = sts_pkg::KIND_STR;
            sts_pkg::MODE_PEND:  k = sts_pkg::single_kind(held);
            default:             has = 1'b0;
        endcase
        return {has, k};
    endfunction

    assign s_fire  = s_valid && s_ready;
    assign m_fire  = m_valid && m_ready;
    assign m_valid = (count_reg != 2'd0);
    assign m_data  = slot_reg[0];
    assign s_ready = (count_reg == 2'd0) || ((count_reg == 2'd1) && m_ready);

    // next scan state and the tokens of the byte on s_data
    always_comb begin
        logic [7:0] c;
        logic       pass;
        logic       do_close;
        logic [5:0] ot;
        logic [4:0] k;

        c        = s_data.text_byte;
        pass     = 1'b0;
        do_close = 1'b0;
        ot       = '0;
        k        = sts_pkg::KIND_END;

        mode_next = mode_reg;
        held_next = held_reg;
        ts_next   = ts_reg;
        tl_next   = tl_reg;
        tln_next  = tln_reg;
        tc_next   = tc_reg;
        off_next  = off_reg;
        line_next = line_reg;
        col_next  = col_reg;
        wb_next   = wb_reg;
        wf_next   = wf_reg;

        for (int i = 0; i < sts_pkg::MAX_RESULTS; i++) res[i] = '0;
        res_n = 2'd0;

        unique case (mode_reg)
            sts_pkg::MODE_NUM: begin
                if (sts_pkg::is_digit(c)) tl_next = inc_sat(tl_reg);
                else begin
                    do_close = 1'b1;
                    pass     = 1'b1;
                end
            end
            sts_pkg::MODE_IDENT: begin
                if (sts_pkg::is_word(c)) begin
                    tl_next = inc_sat(tl_reg);
                    wb_next = {wb_reg[55:0], c};
                    if (tl_next > WORD_MAX) wf_next = 1'b0;
                end else begin
                    do_close = 1'b1;
                    pass     = 1'b1;
                end
            end
            sts_pkg::MODE_STR: begin
                if (c == sts_pkg::CH_QUOTE) do_close = 1'b1;
                else if ((c == sts_pkg::CH_LF) || (c == sts_pkg::CH_CR)) begin
                    do_close = 1'b1;
                    pass     = 1'b1;
                end else tl_next = inc_sat(tl_reg);
            end
            sts_pkg::MODE_COMMENT: begin
                if (c == sts_pkg::CH_LF) begin
                    mode_next = sts_pkg::MODE_IDLE;
                    pass      = 1'b1;
                end
            end
            sts_pkg::MODE_PEND: begin
                if ((held_reg == sts_pkg::CH_SLASH) && (c == sts_pkg::CH_SLASH)) begin
                    mode_next = sts_pkg::MODE_COMMENT;
                end else if ((held_reg == sts_pkg::CH_MINUS) && (c == sts_pkg::CH_GT)) begin
                    res[res_n] = make_tok(sts_pkg::KIND_ARROW, ts_reg, POS_TWO, tln_reg, tc_reg);
                    res_n      = res_n + 2'd1;
                    mode_next  = sts_pkg::MODE_IDLE;
                end else if ((c == sts_pkg::CH_EQ) && ((held_reg == sts_pkg::CH_LT) ||
                             (held_reg == sts_pkg::CH_GT) || (held_reg == sts_pkg::CH_EQ))) begin
                    if (held_reg == sts_pkg::CH_LT)      k = sts_pkg::KIND_LE;
                    else if (held_reg == sts_pkg::CH_GT) k = sts_pkg::KIND_GE;
                    else                                 k = sts_pkg::KIND_EQ;
                    res[res_n] = make_tok(k, ts_reg, POS_TWO, tln_reg, tc_reg);
                    res_n      = res_n + 2'd1;
                    mode_next  = sts_pkg::MODE_IDLE;
                end else begin
                    do_close = 1'b1;
                    pass     = 1'b1;
                end
            end
            default: begin
                mode_next = sts_pkg::MODE_IDLE;
                pass      = 1'b1;
            end
        endcase

        if (do_close) begin
            ot = open_token(mode_reg, held_reg, wf_reg, wb_reg, tl_reg);
            if (ot[5]) begin
                res[res_n] = make_tok(ot[4:0], ts_reg, tl_reg, tln_reg, tc_reg);
                res_n      = res_n + 2'd1;
            end
            mode_next = sts_pkg::MODE_IDLE;
        end

        // byte handled as from the idle state: skip it, emit a token or start one
        if (pass) begin
            if ((c == sts_pkg::CH_SPACE) || (c == sts_pkg::CH_TAB) || (c == sts_pkg::CH_CR)) begin
                // skip blanks
            end else if (c == sts_pkg::CH_LF) begin
                res[res_n] = make_tok(sts_pkg::KIND_EOL, off_reg, POS_ONE, line_reg, col_reg);
                res_n      = res_n + 2'd1;
            end else if (sts_pkg::is_digit(c) || sts_pkg::is_alpha(c) ||
                         (c == sts_pkg::CH_UNDER) || (c == sts_pkg::CH_QUOTE) ||
                         (c == sts_pkg::CH_SLASH) || (c == sts_pkg::CH_MINUS) ||
                         (c == sts_pkg::CH_LT) || (c == sts_pkg::CH_GT) ||
                         (c == sts_pkg::CH_EQ)) begin
                ts_next  = off_reg;
                tln_next = line_reg;
                tc_next  = col_reg;
                tl_next  = POS_ONE;
                if (sts_pkg::is_digit(c)) mode_next = sts_pkg::MODE_NUM;
                else if (sts_pkg::is_alpha(c) || (c == sts_pkg::CH_UNDER)) begin
                    mode_next = sts_pkg::MODE_IDENT;
                    wb_next   = {56'd0, c};
                    wf_next   = 1'b1;
                end else if (c == sts_pkg::CH_QUOTE) begin
                    mode_next = sts_pkg::MODE_STR;
                    tl_next   = '0;
                end else begin
                    mode_next = sts_pkg::MODE_PEND;
                    held_next = c;
                end
            end else begin
                k = sts_pkg::single_kind(c);
                if (k == sts_pkg::KIND_END) k = sts_pkg::KIND_UNK;
                res[res_n] = make_tok(k, off_reg, POS_ONE, line_reg, col_reg);
                res_n      = res_n + 2'd1;
            end
        end

        off_next = inc_sat(off_reg);
        if (c == sts_pkg::CH_LF) begin
            line_next = inc_sat(line_reg);
            col_next  = POS_ONE;
        end else col_next = inc_sat(col_reg);

        // final byte: flush the open token, add the end token, start over
        if (s_data.text_end) begin
            ot = open_token(mode_next, held_next, wf_next, wb_next, tl_next);
            if (ot[5]) begin
                res[res_n] = make_tok(ot[4:0], ts_next, tl_next, tln_next, tc_next);
                res_n      = res_n + 2'd1;
            end
            res[res_n] = make_tok(sts_pkg::KIND_END, off_next, '0, line_next, col_next);
            res_n      = res_n + 2'd1;

            mode_next = sts_pkg::MODE_IDLE;
            held_next = '0;
            ts_next   = '0;
            tl_next   = '0;
            tln_next  = POS_ONE;
            tc_next   = POS_ONE;
            off_next  = '0;
            line_next = POS_ONE;
            col_next  = POS_ONE;
            wb_next   = '0;
            wf_next   = 1'b1;
        end

        if (res_n != 2'd0) res[res_n - 2'd1].run_end = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= sts_pkg::MODE_IDLE;
            held_reg <= '0;
            ts_reg   <= '0;
            tl_reg   <= '0;
            tln_reg  <= POS_ONE;
            tc_reg   <= POS_ONE;
            off_reg  <= '0;
            line_reg <= POS_ONE;
            col_reg  <= POS_ONE;
            wb_reg   <= '0;
            wf_reg   <= 1'b1;
        end else if (s_fire) begin
            mode_reg <= mode_next;
            held_reg <= held_next;
            ts_reg   <= ts_next;
            tl_reg   <= tl_next;
            tln_reg  <= tln_next;
            tc_reg   <= tc_next;
            off_reg  <= off_next;
            line_reg <= line_next;
            col_reg  <= col_next;
            wb_reg   <= wb_next;
            wf_reg   <= wf_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
        end else if (s_fire) begin
            count_reg <= res_n;
        end else if (m_fire) begin
            count_reg <= count_reg - 2'd1;
        end
    end

    // load a new set of tokens, or advance the buffer by one
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            for (int i = 0; i < sts_pkg::MAX_RESULTS; i++) slot_reg[i] <= res[i];
        end else if (m_fire) begin
            for (int i = 0; i < sts_pkg::MAX_RESULTS - 1; i++) slot_reg[i] <= slot_reg[i + 1];
        end
    end

endmodule
